>>> rtl/core/ssp_pkg.sv
package ssp_pkg;

    // Default size of the node space.
    localparam int MAX_NODES_DEFAULT = 64;

    // Field widths of the request and result transactions.
    localparam int REQ_W      = 2;
    localparam int NODE_W     = 6;
    localparam int WEIGHT_W   = 10;
    localparam int DIST_W     = 16;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNREACH    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;
    localparam logic [DIST_W-1:0]  UNREACH_RESET    = 16'd10000;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    // One entry of the distance memory.
    typedef struct packed {
        logic              settled;
        logic [DIST_W-1:0] len;
    } t_dist_entry;

    // One entry of the adjacency matrix.
    typedef struct packed {
        logic                present;
        logic [WEIGHT_W-1:0] weight;
    } t_edge_entry;

endpackage

>>> rtl/core/ssp_req_if.sv
interface ssp_req_if import ssp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [NODE_W-1:0]   from_node;
    logic [NODE_W-1:0]   to_node;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [NODE_W-1:0]   source_node;

    modport source (
        output valid, req_type, from_node, to_node, edge_weight, source_node,
        input  ready
    );
    modport sink (
        input  valid, req_type, from_node, to_node, edge_weight, source_node,
        output ready
    );
endinterface

>>> rtl/core/ssp_res_if.sv
interface ssp_res_if import ssp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node_index;
    logic [DIST_W-1:0] path_length;
    logic              last_node;

    modport source (
        output valid, node_index, path_length, last_node,
        input  ready
    );
    modport sink (
        input  valid, node_index, path_length, last_node,
        output ready
    );
endinterface

>>> rtl/core/single_source_shortest_paths_core.sv
// Channel    Direction  Handshake      Payload
// i_req      in         valid/ready    req_type, from_node, to_node, edge_weight, source_node
// o_res      out        valid/ready    node_index, path_length, last_node
// i_cfg_*    in         write enable   i_cfg_idx selects the register, i_cfg_data the value
//
// Steps: an edge write goes straight into the edge memory. A clear sweeps all MAX_NODES^2
// entries (rounded up to a power of two per side, 4096 at the default size) one entry per
// cycle. A run first initialises every node in use, then makes one relaxation pass over
// the n nodes for every node that gets settled, then reads and emits each result in turn.
// Reset starts the same clearing sweep; no request transaction is taken until it ends.
// A stalled result only stops the run while it emits results; after the last result is
// loaded the block takes new requests even if that result has not been taken yet.

module single_source_shortest_paths_core import ssp_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ssp_req_if.sink               i_req,
    ssp_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Node index width, counter width (holds the node count itself) and edge address width.
    localparam int NW         = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW         = $clog2(MAX_NODES + 1);
    localparam int EAW        = 2 * NW;
    localparam int EDGE_DEPTH = 1 << EAW;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_INIT   = 6'b000100,
        ST_RELAX  = 6'b001000,
        ST_OUT_RD = 6'b010000,
        ST_OUT_WR = 6'b100000
    } t_state;

    // The distance memory holds the tentative distance and the settled flag of every node.
    // The edge memory is the adjacency matrix, row = tail node, column = head node.
    t_dist_entry m_dist [MAX_NODES];
    t_edge_entry m_edge [EDGE_DEPTH];

    t_state              r_state, n_state;
    logic [EAW-1:0]      r_clr, n_clr;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_n, n_n;
    logic [NODE_W-1:0]   r_src, n_src;
    logic [NW-1:0]       r_best, n_best;
    logic [DIST_W-1:0]   r_bestd, n_bestd;
    logic                r_nbv, n_nbv;
    logic [NW-1:0]       r_nb, n_nb;
    logic [DIST_W-1:0]   r_nbd, n_nbd;
    logic                r_s2_v, n_s2_v;
    logic [NW-1:0]       r_s2_idx, n_s2_idx;
    logic                r_ov, n_ov;
    logic [NODE_W-1:0]   r_o_idx, n_o_idx;
    logic [DIST_W-1:0]   r_o_len, n_o_len;
    logic                r_o_last, n_o_last;
    logic [COUNT_W-1:0]  r_node_count, n_node_count;
    logic [DIST_W-1:0]   r_lim, n_lim;
    t_dist_entry         r_dq;
    t_edge_entry         r_eq;

    logic                dist_we;
    logic [NW-1:0]       dist_wa;
    t_dist_entry         dist_wd;
    logic                edge_we;
    logic [EAW-1:0]      edge_wa;
    t_edge_entry         edge_wd;

    logic [CW-1:0]       run_n;
    logic                src_ok;
    logic                idx_last;
    logic                edge_in_range;
    logic                s2_is_best;
    logic                s2_set;
    logic                s2_cand;
    logic [DIST_W:0]     s2_sum;
    logic [DIST_W-1:0]   s2_sat;
    logic [DIST_W-1:0]   s2_dist;
    logic                s2_last;
    logic                t_upd;
    logic                t_nbv;
    logic [NW-1:0]       t_nb;
    logic [DIST_W-1:0]   t_nbd;

    assign i_req.ready = (r_state == ST_IDLE);

    assign o_res.valid       = r_ov;
    assign o_res.node_index  = r_o_idx;
    assign o_res.path_length = r_o_len;
    assign o_res.last_node   = r_o_last;

    // A node count of zero runs one node; a count above the node space is clipped to it.
    always_comb begin
        if (r_node_count == '0) begin
            run_n = CW'(1);
        end else if (9'(r_node_count) > 9'(MAX_NODES)) begin
            run_n = CW'(MAX_NODES);
        end else begin
            run_n = CW'(r_node_count);
        end
    end

    assign edge_in_range = (9'(i_req.from_node) < 9'(MAX_NODES)) &&
                           (9'(i_req.to_node) < 9'(MAX_NODES));
    assign src_ok        = (9'(r_src) < 9'(r_n));
    assign idx_last      = (CW'(r_idx + CW'(1)) == r_n);

    // Second relaxation stage: the distance and edge entries read in the cycle before are
    // combined, written back, and folded into the search for the next node to settle.
    // The node being expanded gets its settled flag in this same write.
    assign s2_is_best = (r_s2_idx == r_best);
    assign s2_set     = r_dq.settled | s2_is_best;
    assign s2_cand    = r_eq.present & ~s2_set;
    assign s2_sum     = (DIST_W + 1)'(r_bestd) + (DIST_W + 1)'(r_eq.weight);
    assign s2_sat     = (s2_sum > (DIST_W + 1)'(r_lim)) ? r_lim : s2_sum[DIST_W-1:0];
    assign s2_dist    = (s2_cand && (s2_sat < r_dq.len)) ? s2_sat : r_dq.len;
    assign s2_last    = (CW'(r_s2_idx) == CW'(r_n - CW'(1)));

    // Strict compare in ascending node order keeps the lowest index on a tie.
    assign t_upd = r_s2_v & ~s2_set & (s2_dist < r_nbd);
    assign t_nbv = r_nbv | t_upd;
    assign t_nb  = t_upd ? r_s2_idx : r_nb;
    assign t_nbd = t_upd ? s2_dist : r_nbd;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_idx        = r_idx;
        n_n          = r_n;
        n_src        = r_src;
        n_best       = r_best;
        n_bestd      = r_bestd;
        n_nbv        = r_nbv;
        n_nb         = r_nb;
        n_nbd        = r_nbd;
        n_s2_v       = r_s2_v;
        n_s2_idx     = r_s2_idx;
        n_ov         = r_ov;
        n_o_idx      = r_o_idx;
        n_o_len      = r_o_len;
        n_o_last     = r_o_last;
        n_node_count = r_node_count;
        n_lim        = r_lim;
        dist_we      = 1'b0;
        dist_wa      = '0;
        dist_wd      = '0;
        edge_we      = 1'b0;
        edge_wa      = '0;
        edge_wd      = '0;

        // The output register empties when its transaction completes.
        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                edge_we = 1'b1;
                edge_wa = r_clr;
                n_clr   = EAW'(r_clr + EAW'(1));
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    case (t_req'(i_req.req_type))
                        REQ_WRITE: begin
                            if (edge_in_range) begin
                                edge_we                = 1'b1;
                                edge_wa                = {NW'(i_req.from_node),
                                                          NW'(i_req.to_node)};
                                edge_wd.present        = 1'b1;
                                edge_wd.weight         = i_req.edge_weight;
                            end
                        end
                        REQ_RUN: begin
                            n_n     = run_n;
                            n_src   = i_req.source_node;
                            n_idx   = '0;
                            n_state = ST_INIT;
                        end
                        REQ_CLEAR: begin
                            n_clr   = '0;
                            n_state = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INIT: begin
                // Every node in use starts unsettled at the ceiling, the source at zero.
                dist_we         = 1'b1;
                dist_wa         = r_idx[NW-1:0];
                dist_wd.settled = 1'b0;
                dist_wd.len     = (src_ok && (9'(r_idx) == 9'(r_src))) ? '0 : r_lim;
                n_idx           = CW'(r_idx + CW'(1));
                if (idx_last) begin
                    n_idx = '0;
                    n_nbv = 1'b0;
                    n_nbd = r_lim;
                    // The first node to settle is the source, if its zero lies below the ceiling.
                    if (src_ok && (r_lim != '0)) begin
                        n_best  = NW'(r_src);
                        n_bestd = '0;
                        n_state = ST_RELAX;
                    end else begin
                        n_state = ST_OUT_RD;
                    end
                end
            end
            ST_RELAX: begin
                if (r_idx < r_n) begin
                    n_idx    = CW'(r_idx + CW'(1));
                    n_s2_v   = 1'b1;
                    n_s2_idx = r_idx[NW-1:0];
                end else begin
                    n_s2_v = 1'b0;
                end
                if (r_s2_v) begin
                    dist_we         = 1'b1;
                    dist_wa         = r_s2_idx;
                    dist_wd.settled = s2_set;
                    dist_wd.len     = s2_dist;
                    n_nbv           = t_nbv;
                    n_nb            = t_nb;
                    n_nbd           = t_nbd;
                    if (s2_last) begin
                        // The round is done: settle the minimum found, or emit results.
                        n_idx = '0;
                        if (t_nbv) begin
                            n_best  = t_nb;
                            n_bestd = t_nbd;
                            n_nbv   = 1'b0;
                            n_nbd   = r_lim;
                        end else begin
                            n_state = ST_OUT_RD;
                        end
                    end
                end
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_WR;
            end
            ST_OUT_WR: begin
                if (!r_ov || o_res.ready) begin
                    n_ov     = 1'b1;
                    n_o_idx  = NODE_W'(r_idx);
                    n_o_len  = r_dq.len;
                    n_o_last = idx_last;
                    if (idx_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = CW'(r_idx + CW'(1));
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NODE_COUNT: n_node_count = i_cfg_data[COUNT_W-1:0];
                CFG_UNREACH:    n_lim        = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_idx        <= '0;
            r_nbv        <= 1'b0;
            r_s2_v       <= 1'b0;
            r_ov         <= 1'b0;
            r_node_count <= NODE_COUNT_RESET;
            r_lim        <= UNREACH_RESET;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_idx        <= n_idx;
            r_nbv        <= n_nbv;
            r_s2_v       <= n_s2_v;
            r_ov         <= n_ov;
            r_node_count <= n_node_count;
            r_lim        <= n_lim;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_src    <= n_src;
        r_best   <= n_best;
        r_bestd  <= n_bestd;
        r_nb     <= n_nb;
        r_nbd    <= n_nbd;
        r_s2_idx <= n_s2_idx;
        r_o_idx  <= n_o_idx;
        r_o_len  <= n_o_len;
        r_o_last <= n_o_last;
    end

    // Reads walk in ascending order and each entry is written back the cycle after its
    // read, so a read never meets a pending write to the same entry.
    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            m_dist[dist_wa] <= dist_wd;
        end
        r_dq <= m_dist[r_idx[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            m_edge[edge_wa] <= edge_wd;
        end
        r_eq <= m_edge[{r_best, r_idx[NW-1:0]}];
    end

endmodule

>>> rtl/core/ssp_core_chk.sv
module ssp_core_chk import ssp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [NODE_W-1:0] i_out_node_index,
    input logic [DIST_W-1:0] i_out_path_length,
    input logic              i_out_last
);

    // Node index expected on the next result transaction.
    logic [NODE_W-1:0] r_exp_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_exp_idx <= i_out_last ? '0 : NODE_W'(i_out_node_index + NODE_W'(1));
        end
    end

    // The edge memory is swept after reset, so no request is taken right after it.
    a_reset_sweep: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("request taken right after reset");

    // Within a run no new request is taken before its last result.
    a_busy_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |-> !i_in_ready)
        else $error("request taken in the middle of a run");

    // Results come in node order, starting at node zero.
    a_node_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_node_index == r_exp_idx))
        else $error("result out of node order");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_node_index) && $stable(i_out_path_length) &&
         $stable(i_out_last)))
        else $error("stalled result changed");

endmodule

bind single_source_shortest_paths_core ssp_core_chk u_ssp_core_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_req.ready),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_out_node_index  (o_res.node_index),
    .i_out_path_length (o_res.path_length),
    .i_out_last        (o_res.last_node)
);
